// ===== src/uep0_pkg.sv =====
package uep0_pkg;

    // Bus event codes carried in the input tuser.
    localparam logic [1:0] OP_SETUP    = 2'd0;
    localparam logic [1:0] OP_TX_READY = 2'd1;
    localparam logic [1:0] OP_CONNECT  = 2'd2;

    // Result actions.
    localparam logic [3:0] ACT_NONE       = 4'd0;
    localparam logic [3:0] ACT_STATUS     = 4'd1;
    localparam logic [3:0] ACT_HUB_SET    = 4'd2;
    localparam logic [3:0] ACT_HUB_CLEAR  = 4'd3;
    localparam logic [3:0] ACT_DATA_START = 4'd4;
    localparam logic [3:0] ACT_SET_ADDR   = 4'd5;
    localparam logic [3:0] ACT_SET_CONFIG = 4'd6;
    localparam logic [3:0] ACT_CHUNK      = 4'd7;
    localparam logic [3:0] ACT_APPLY_ADDR = 4'd8;
    localparam logic [3:0] ACT_FORWARD    = 4'd9;
    localparam logic [3:0] ACT_RESET      = 4'd10;

    // Data sources.
    localparam logic [1:0] SRC_NONE       = 2'd0;
    localparam logic [1:0] SRC_DEVICE     = 2'd1;
    localparam logic [1:0] SRC_CONFIG     = 2'd2;
    localparam logic [1:0] SRC_HUB_STATUS = 2'd3;

    // bmRequestType values.
    localparam logic [7:0] RT_HUB_CLASS_IN  = 8'hA3;
    localparam logic [7:0] RT_HUB_CLASS_OUT = 8'h23;
    localparam logic [7:0] RT_STD_DEVICE    = 8'h00;
    localparam logic [7:0] RT_STD_DEV_IN    = 8'h80;
    localparam logic [7:0] RT_STD_IFACE     = 8'h01;
    localparam logic [7:0] RT_STD_ENDPOINT  = 8'h02;

    // bRequest values.
    localparam logic [7:0] RC_GET_STATUS    = 8'h00;
    localparam logic [7:0] RC_CLEAR_FEATURE = 8'h01;
    localparam logic [7:0] RC_SET_FEATURE   = 8'h03;
    localparam logic [7:0] RC_SET_ADDRESS   = 8'h05;
    localparam logic [7:0] RC_GET_DESC      = 8'h06;
    localparam logic [7:0] RC_SET_CONFIG    = 8'h09;
    localparam logic [7:0] RC_SET_IFACE     = 8'h0B;

    // Descriptor types in the high byte of wValue.
    localparam logic [7:0] DT_DEVICE = 8'h01;
    localparam logic [7:0] DT_CONFIG = 8'h02;

    localparam logic [15:0] HUB_STATUS_BYTES = 16'd4;
    localparam logic [6:0]  MPS_MIN          = 7'd8;
    localparam logic [6:0]  MPS_MAX          = 7'd64;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_PACKET  = 2'd0;
    localparam logic [1:0] CFG_DEVICE_LEN  = 2'd1;
    localparam logic [1:0] CFG_CONFIG_LEN  = 2'd2;
    localparam logic [1:0] CFG_DESC_PRESENT = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] setup_value;
        logic [15:0] setup_index;
        logic [15:0] setup_length;
    } t_item;

    typedef struct packed {
        logic [6:0]  max_packet_size;
        logic [7:0]  device_desc_length;
        logic [15:0] config_desc_length;
        logic        descriptors_present;
    } t_cfg;

    typedef struct packed {
        logic        data_stage_active;
        logic [15:0] bytes_remaining;
        logic [15:0] source_offset;
        logic [1:0]  active_source;
        logic [7:0]  held_address;
        logic        address_waiting;
    } t_state;

    typedef struct packed {
        logic [3:0]  action;
        logic [1:0]  data_source;
        logic [7:0]  out_request_type;
        logic [7:0]  out_request_code;
        logic [15:0] out_value;
        logic [15:0] out_index;
        logic [15:0] out_length;
        logic [7:0]  device_address;
        logic [15:0] chunk_offset;
        logic [6:0]  chunk_count;
        logic        last;
    } t_result;

endpackage

// ===== src/uep0_decode.sv =====
module uep0_decode
    import uep0_pkg::*;
(
    input  t_item   i_item,
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    output t_result o_res0,
    output t_result o_res1,
    output logic    o_two,
    output t_state  o_next
);

    logic        decode;
    logic [3:0]  cls_action;
    logic        start;
    logic [1:0]  start_src;
    logic [15:0] start_total;
    logic [15:0] desc_len;
    logic [6:0]  mps;
    logic [6:0]  cnt;
    t_state      chunk_in;
    t_state      chunk_next;
    t_result     chunk_res;
    t_result     echo;

    assign decode = (i_item.operation == OP_SETUP) && !i_state.data_stage_active;

    // Request classification.
    always_comb begin
        cls_action  = ACT_FORWARD;
        start       = 1'b0;
        start_src   = SRC_NONE;
        desc_len    = 16'd0;
        if (i_item.request_type == RT_HUB_CLASS_IN ||
            i_item.request_type == RT_HUB_CLASS_OUT) begin
            if (i_item.request_code == RC_SET_FEATURE) begin
                cls_action = ACT_HUB_SET;
            end else if (i_item.request_code == RC_CLEAR_FEATURE) begin
                cls_action = ACT_HUB_CLEAR;
            end else if (i_item.request_code == RC_GET_STATUS) begin
                cls_action = ACT_DATA_START;
                start      = 1'b1;
                start_src  = SRC_HUB_STATUS;
            end
        end else if (i_item.request_type == RT_STD_DEVICE) begin
            if (i_item.request_code == RC_SET_ADDRESS) begin
                cls_action = ACT_SET_ADDR;
            end else if (i_item.request_code == RC_SET_CONFIG) begin
                cls_action = ACT_SET_CONFIG;
            end
        end else if (i_item.request_type == RT_STD_DEV_IN) begin
            if (i_item.request_code == RC_GET_DESC && i_cfg.descriptors_present) begin
                if (i_item.setup_value[15:8] == DT_DEVICE) begin
                    cls_action = ACT_DATA_START;
                    start      = 1'b1;
                    start_src  = SRC_DEVICE;
                    desc_len   = {8'd0, i_cfg.device_desc_length};
                end else if (i_item.setup_value[15:8] == DT_CONFIG) begin
                    cls_action = ACT_DATA_START;
                    start      = 1'b1;
                    start_src  = SRC_CONFIG;
                    desc_len   = i_cfg.config_desc_length;
                end
            end
        end else if (i_item.request_type == RT_STD_IFACE) begin
            if (i_item.request_code == RC_SET_IFACE) begin
                cls_action = ACT_STATUS;
            end
        end else if (i_item.request_type == RT_STD_ENDPOINT) begin
            if (i_item.request_code == RC_CLEAR_FEATURE) begin
                cls_action = ACT_STATUS;
            end
        end
    end

    // Hub status is always four bytes; descriptors are capped by wLength.
    always_comb begin
        if (start_src == SRC_HUB_STATUS) begin
            start_total = HUB_STATUS_BYTES;
        end else if (desc_len > i_item.setup_length) begin
            start_total = i_item.setup_length;
        end else begin
            start_total = desc_len;
        end
    end

    // One chunk unit serves both the first chunk of a new data stage and
    // every later chunk.
    always_comb begin
        chunk_in = i_state;
        if (decode && start) begin
            chunk_in.data_stage_active = 1'b1;
            chunk_in.bytes_remaining   = start_total;
            chunk_in.source_offset     = 16'd0;
            chunk_in.active_source     = start_src;
        end
    end

    always_comb begin
        if (i_cfg.max_packet_size < MPS_MIN) begin
            mps = MPS_MIN;
        end else if (i_cfg.max_packet_size > MPS_MAX) begin
            mps = MPS_MAX;
        end else begin
            mps = i_cfg.max_packet_size;
        end
        if (chunk_in.bytes_remaining > {9'd0, mps}) begin
            cnt = mps;
        end else begin
            cnt = chunk_in.bytes_remaining[6:0];
        end
    end

    always_comb begin
        chunk_res              = '0;
        chunk_res.action       = ACT_CHUNK;
        chunk_res.data_source  = chunk_in.active_source;
        chunk_res.chunk_offset = chunk_in.source_offset;
        chunk_res.chunk_count  = cnt;
        chunk_next                 = chunk_in;
        chunk_next.source_offset   = chunk_in.source_offset + {9'd0, cnt};
        chunk_next.bytes_remaining = chunk_in.bytes_remaining - {9'd0, cnt};
        if (chunk_next.bytes_remaining == 16'd0) begin
            chunk_next.data_stage_active = 1'b0;
            chunk_next.active_source     = SRC_NONE;
        end
    end

    always_comb begin
        echo                  = '0;
        echo.action           = cls_action;
        echo.out_request_type = i_item.request_type;
        echo.out_request_code = i_item.request_code;
        echo.out_value        = i_item.setup_value;
        echo.out_index        = i_item.setup_index;
        echo.out_length       = i_item.setup_length;
    end

    always_comb begin
        o_res0 = '0;
        o_res1 = '0;
        o_two  = 1'b0;
        o_next = i_state;
        if (decode) begin
            o_res0 = echo;
            if (start) begin
                o_res0.data_source = start_src;
                o_res0.out_length  = start_total;
                o_res1             = chunk_res;
                o_two              = 1'b1;
                o_next             = chunk_next;
            end else if (cls_action == ACT_SET_ADDR) begin
                o_res0.device_address  = i_item.setup_value[7:0];
                o_next.held_address    = i_item.setup_value[7:0];
                o_next.address_waiting = 1'b1;
            end
        end else if (i_item.operation == OP_SETUP || i_item.operation == OP_TX_READY) begin
            if (i_state.data_stage_active) begin
                o_res0 = chunk_res;
                o_next = chunk_next;
            end else if (i_state.address_waiting) begin
                o_res0.action          = ACT_APPLY_ADDR;
                o_res0.device_address  = i_state.held_address;
                o_next.address_waiting = 1'b0;
            end
        end else if (i_item.operation == OP_CONNECT) begin
            o_res0.action            = ACT_RESET;
            o_next.data_stage_active = 1'b0;
            o_next.address_waiting   = 1'b0;
        end
        if (o_two) begin
            o_res1.last = 1'b1;
        end else begin
            o_res0.last = 1'b1;
        end
    end

endmodule

// ===== src/uep0_out_fifo.sv =====
module uep0_out_fifo
    import uep0_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  logic    i_two,
    input  t_result i_res0,
    input  t_result i_res1,
    output logic [1:0] o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    t_result    r_mem [0:1];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;
    logic [1:0] n_count;

    assign o_valid = (r_count != 2'd0);
    assign pop     = o_valid && i_ready;
    assign o_res   = r_mem[r_rd_ptr];
    // Free slots once this cycle's transfer has left.
    assign o_free  = 2'd2 - r_count + {1'b0, pop};

    always_comb begin
        n_count = r_count - {1'b0, pop};
        if (i_push) begin
            n_count = n_count + (i_two ? 2'd2 : 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_res0;
            if (i_two) begin
                r_mem[~r_wr_ptr] <= i_res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr ^ ~i_two;
            end
        end
    end

endmodule

// ===== src/usb_ep0_control_request_handler_top.sv =====
// USB device endpoint-zero control handler.
// The slave stream carries one bus event per transfer: tuser holds the event
// code (setup packet, endpoint-zero transmit ready, cable connect) and tdata
// the decoded setup packet fields. The master stream returns one or two
// result transfers per event; tlast marks the final result of an event.
// A hub-class get status, or a get descriptor for the device or configuration
// descriptor while descriptors are installed, yields a data start result and
// then the first chunk; each later transmit-ready or setup event in the data
// stage yields the next chunk. A set address is held and reported as an apply
// address on the next transmit-ready event outside a data stage.
// An accepted event is registered, decoded combinationally and written into a
// two-entry result buffer that drives the master side. One event per cycle when
// it gives one result and the receiver takes each; an event with two results
// waits until both fit, as the buffer gives one read transfer per cycle.
// Reset clears the endpoint state and loads the configuration defaults
// (packet size 8, device descriptor 18 bytes, no descriptors installed).
// When the receiver stalls, results wait in the buffer and the input register
// holds one more event; tready drops once both are full.
// Configuration writes are taken at any edge with i_cfg_we high, but are
// only meant while the block is idle.
module usb_ep0_control_request_handler_top
    import uep0_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] request_type, [15:8] request_code, [31:16] setup_value,
    // [47:32] setup_index, [63:48] setup_length
    input  logic [63:0] i_s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  i_s_axis_tuser,
    // Master stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] out_request_type, [15:8] out_request_code, [31:16] out_value,
    // [47:32] out_index, [63:48] out_length, [71:64] device_address,
    // [87:72] chunk_offset, [94:88] chunk_count, [95] zero
    output logic [95:0] o_m_axis_tdata,
    // [3:0] action, [5:4] data_source
    output logic [5:0]  o_m_axis_tuser,
    output logic        o_m_axis_tlast,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_item      r_in;
    logic       r_in_valid;
    t_cfg       r_cfg;
    t_state     r_state;

    t_result    res0;
    t_result    res1;
    t_result    out_res;
    logic       two;
    t_state     n_state;
    logic [1:0] fifo_free;
    logic       consume;
    logic       s_accept;

    // The registered event moves on only when the buffer has room for all of
    // its results.
    assign consume         = r_in_valid && (fifo_free >= (two ? 2'd2 : 2'd1));
    assign o_s_axis_tready = !r_in_valid || consume;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in.operation    <= i_s_axis_tuser;
            r_in.request_type <= i_s_axis_tdata[7:0];
            r_in.request_code <= i_s_axis_tdata[15:8];
            r_in.setup_value  <= i_s_axis_tdata[31:16];
            r_in.setup_index  <= i_s_axis_tdata[47:32];
            r_in.setup_length <= i_s_axis_tdata[63:48];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
            r_cfg.max_packet_size     <= 7'd8;
            r_cfg.device_desc_length  <= 8'd18;
            r_cfg.config_desc_length  <= 16'd0;
            r_cfg.descriptors_present <= 1'b0;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_PACKET:   r_cfg.max_packet_size     <= i_cfg_data[6:0];
                    CFG_DEVICE_LEN:   r_cfg.device_desc_length  <= i_cfg_data[7:0];
                    CFG_CONFIG_LEN:   r_cfg.config_desc_length  <= i_cfg_data;
                    CFG_DESC_PRESENT: r_cfg.descriptors_present <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    uep0_decode u_decode (
        .i_item  (r_in),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_two   (two),
        .o_next  (n_state)
    );

    uep0_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (consume),
        .i_two   (two),
        .i_res0  (res0),
        .i_res1  (res1),
        .o_free  (fifo_free),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (out_res)
    );

    assign o_m_axis_tdata = {1'b0, out_res.chunk_count, out_res.chunk_offset,
                             out_res.device_address, out_res.out_length,
                             out_res.out_index, out_res.out_value,
                             out_res.out_request_code, out_res.out_request_type};
    assign o_m_axis_tuser = {out_res.data_source, out_res.action};
    assign o_m_axis_tlast = out_res.last;

endmodule
